FILE: hdl/bah_pkg.sv
// shared types and constants for the barometric altitude hold block
// no dependencies; imported by every module under hdl
package bah_pkg;

  // configuration port geometry
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // register indexes (byte address bits [4:2])
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_ORIGIN = 3'd1;
  localparam logic [2:0] REG_TCOEF  = 3'd2;
  localparam logic [2:0] REG_PROP   = 3'd3;
  localparam logic [2:0] REG_DIFF   = 3'd4;

  // stream word widths
  localparam int IN_DW  = 24;
  localparam int OUT_DW = 24;

  // compensation rounding and limits
  localparam logic signed [25:0] COMP_ROUND = 26'sd16;
  localparam logic signed [16:0] ERR_LO     = -17'sd3;
  localparam logic signed [16:0] ERR_HI     = 17'sd8;
  localparam logic signed [6:0]  SUM_LO     = -7'sd16;
  localparam logic signed [6:0]  SUM_HI     = 7'sd16;
  localparam logic signed [6:0]  ITERM_LO   = -7'sd4;
  localparam logic signed [6:0]  ITERM_HI   = 7'sd4;
  localparam logic signed [12:0] DTERM_LO   = -13'sd8;
  localparam logic signed [12:0] DTERM_HI   = 13'sd8;
  localparam logic signed [13:0] DRIVE_LO   = -14'sd5;
  localparam logic signed [13:0] DRIVE_HI   = 14'sd15;

  // configuration register contents
  typedef struct packed {
    logic               enable;
    logic signed [15:0] origin;
    logic signed [7:0]  tcoef;
    logic signed [7:0]  prop;
    logic signed [7:0]  diff;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;     // latch input word
    logic store_temp;  // keep temperature reading
    logic comp_mul;    // temperature times coefficient
    logic alt_upd;     // altitude correction and filter
    logic pid_err;     // error, integral and both products
    logic pid_drive;   // sum terms and clamp drive
    logic load_out;    // copy result into output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic expect_temp;
  } stat_t;

endpackage

FILE: hdl/bah_cfg_regs.sv
// apb-style configuration registers for the altitude hold block
// depends on bah_pkg
module bah_cfg_regs
  import bah_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_ENABLE: cfg_r.enable <= pwdata[0];
        REG_ORIGIN: cfg_r.origin <= pwdata[15:0];
        REG_TCOEF:  cfg_r.tcoef  <= pwdata[7:0];
        REG_PROP:   cfg_r.prop   <= pwdata[7:0];
        REG_DIFF:   cfg_r.diff   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[4:2])
      REG_ENABLE: prdata = {31'd0, cfg_r.enable};
      REG_ORIGIN: prdata = {16'd0, cfg_r.origin};
      REG_TCOEF:  prdata = {24'd0, cfg_r.tcoef};
      REG_PROP:   prdata = {24'd0, cfg_r.prop};
      REG_DIFF:   prdata = {24'd0, cfg_r.diff};
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: hdl/bah_ctrl.sv
// sequencing state machine for the altitude hold block
// depends on bah_pkg; drives bah_datapath through cmd_t
module bah_ctrl
  import bah_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  enable,
  input  stat_t stat,
  input  logic  in_tvalid,
  output logic  in_tready,
  output logic  out_tvalid,
  input  logic  out_tready,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEMP,
    S_COMP,
    S_ALT,
    S_PID,
    S_DRIVE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = ~out_valid_r | out_tready;

  // command decode per state
  always_comb begin
    cmd            = '0;
    cmd.capture    = (state_r == S_IDLE) & in_tvalid;
    cmd.store_temp = (state_r == S_TEMP);
    cmd.comp_mul   = (state_r == S_COMP);
    cmd.alt_upd    = (state_r == S_ALT);
    cmd.pid_err    = (state_r == S_PID);
    cmd.pid_drive  = (state_r == S_DRIVE);
    cmd.load_out   = (state_r == S_DONE) & out_free;
  end

  // next state and output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (!enable) begin
            state_nxt = S_DONE;
          end else if (stat.expect_temp) begin
            state_nxt = S_TEMP;
          end else begin
            state_nxt = S_COMP;
          end
        end
      end
      S_TEMP:  state_nxt = S_DONE;
      S_COMP:  state_nxt = S_ALT;
      S_ALT:   state_nxt = S_PID;
      S_PID:   state_nxt = S_DRIVE;
      S_DRIVE: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/bah_datapath.sv
// altitude correction, filter and clamped pid datapath
// depends on bah_pkg; stepped by bah_ctrl commands
module bah_datapath
  import bah_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [IN_DW-1:0]  in_word,
  output logic [OUT_DW-1:0] out_word
);

  // input capture
  logic [15:0]        reading_r;
  logic               moving_r;
  // persistent state
  logic               expect_r;
  logic [15:0]        last_temp_r;
  logic signed [15:0] filt_r;
  logic signed [15:0] target_r;
  logic signed [5:0]  err_sum_r;
  logic signed [4:0]  last_err_r;
  logic signed [4:0]  drive_r;
  // stage registers
  logic signed [24:0] tprod_r;
  logic signed [4:0]  err_r;
  logic signed [12:0] pprod_r;
  logic signed [12:0] dprod_r;
  logic [OUT_DW-1:0]  out_r;

  // altitude path
  logic signed [25:0] comp_sum;
  logic [15:0]        comp16;
  logic [15:0]        alt;
  logic signed [16:0] filt_sum;
  logic signed [15:0] filt_nxt;
  // error path
  logic signed [16:0] err_raw;
  logic signed [4:0]  err;
  logic signed [6:0]  sum_raw;
  logic signed [5:0]  sum_nxt;
  logic signed [4:0]  err_delta;
  // drive path
  logic signed [6:0]  sum_x2;
  logic signed [6:0]  iterm;
  logic signed [12:0] dterm;
  logic signed [13:0] d_total;
  logic signed [13:0] d_neg;
  logic signed [4:0]  drive_nxt;

  assign stat.expect_temp = expect_r;
  assign out_word         = out_r;

  // temperature compensation and rounded mean filter
  always_comb begin
    comp_sum = tprod_r + COMP_ROUND;
    comp16   = comp_sum[20:5];
    alt      = cfg.origin - reading_r - comp16;
    filt_sum = {filt_r[15], filt_r} + {alt[15], alt} + 17'sd1;
    filt_nxt = filt_sum[16:1];
  end

  // clamped error and integral
  always_comb begin
    err_raw = {filt_r[15], filt_r} - {target_r[15], target_r};
    if (err_raw < ERR_LO) begin
      err = ERR_LO[4:0];
    end else if (err_raw > ERR_HI) begin
      err = ERR_HI[4:0];
    end else begin
      err = err_raw[4:0];
    end
    sum_raw = {err_sum_r[5], err_sum_r} + {{2{err[4]}}, err};
    if (sum_raw < SUM_LO) begin
      sum_nxt = SUM_LO[5:0];
    end else if (sum_raw > SUM_HI) begin
      sum_nxt = SUM_HI[5:0];
    end else begin
      sum_nxt = sum_raw[5:0];
    end
    err_delta = last_err_r - err;
  end

  // term sum and drive clamp
  always_comb begin
    sum_x2 = {err_sum_r, 1'b0};
    if (sum_x2 < ITERM_LO) begin
      iterm = ITERM_LO;
    end else if (sum_x2 > ITERM_HI) begin
      iterm = ITERM_HI;
    end else begin
      iterm = sum_x2;
    end
    if (dprod_r < DTERM_LO) begin
      dterm = DTERM_LO;
    end else if (dprod_r > DTERM_HI) begin
      dterm = DTERM_HI;
    end else begin
      dterm = dprod_r;
    end
    d_total = {pprod_r[12], pprod_r} + {{7{iterm[6]}}, iterm} + {dterm[12], dterm};
    d_neg   = -d_total;
    if (d_neg < DRIVE_LO) begin
      drive_nxt = DRIVE_LO[4:0];
    end else if (d_neg > DRIVE_HI) begin
      drive_nxt = DRIVE_HI[4:0];
    end else begin
      drive_nxt = d_neg[4:0];
    end
  end

  // control-visible state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r    <= 1'b1;
      last_temp_r <= '0;
      filt_r      <= '0;
      target_r    <= '0;
      err_sum_r   <= '0;
      last_err_r  <= '0;
      drive_r     <= '0;
    end else begin
      if (cmd.store_temp) begin
        last_temp_r <= reading_r;
        expect_r    <= 1'b0;
      end
      if (cmd.alt_upd) begin
        filt_r   <= filt_nxt;
        expect_r <= 1'b1;
        if (moving_r) begin
          target_r   <= filt_nxt;
          err_sum_r  <= '0;
          last_err_r <= '0;
        end
      end
      if (cmd.pid_err) begin
        err_sum_r <= sum_nxt;
      end
      if (cmd.pid_drive) begin
        drive_r    <= drive_nxt;
        last_err_r <= err_r;
      end
    end
  end

  // payload and stage registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      reading_r <= in_word[15:0];
      moving_r  <= in_word[16];
    end
    if (cmd.comp_mul) begin
      tprod_r <= $signed({1'b0, last_temp_r}) * cfg.tcoef;
    end
    if (cmd.pid_err) begin
      err_r   <= err;
      pprod_r <= err * cfg.prop;
      dprod_r <= err_delta * cfg.diff;
    end
    if (cmd.load_out) begin
      out_r <= {2'b00, expect_r, filt_r, drive_r};
    end
  end

endmodule

FILE: hdl/baro_altitude_hold.sv
// top level of the barometric altitude hold block
// depends on bah_pkg, bah_cfg_regs, bah_ctrl, bah_datapath
//
//  channel | direction | word layout (lsb first)
//  --------+-----------+----------------------------------------------------
//  in_     | slave     | reading[15:0], throttle_moving[16], zero pad [23:17]
//  out_    | master    | climb_drive[4:0], altitude[20:5],
//          |           | next_is_temperature[21], zero pad [23:22]
//  apb     | slave     | enable, origin_altitude, temp_coefficient,
//          |           | prop_gain, diff_gain at byte addresses 0,4,8,12,16
//
// a pressure word runs through the idle state that accepts it, then the
// multiply, filter, error, drive and load steps; a temperature word runs
// through idle, temperature store and load, and a word while disabled
// through idle and load; the single shared sequencer orders these steps.
// in_tready is high only while idle; a waiting result holds only the next load.
// rst_n is synchronous, active low, and clears configuration, state and valid.
module baro_altitude_hold
  import bah_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // reading[15:0], throttle_moving[16]
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // climb_drive[4:0], altitude[20:5],
                                        // next_is_temperature[21]
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  bah_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bah_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .enable     (cfg.enable),
    .stat       (stat),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  bah_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .in_word  (in_tdata),
    .out_word (out_tdata)
  );

endmodule
